@@ hw/rtl/sws_pkg.sv @@
// Shared types and constants for the stack with search and delete.
// No dependencies; compile this file first.
package sws_pkg;

  localparam int DEPTH    = 64;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 38;
  localparam int POS_W    = 6;
  localparam int FILL_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_SEARCH = 3'd2,
    OP_DELETE = 3'd3,
    OP_MAX    = 3'd4,
    OP_MIN    = 3'd5,
    OP_SUM    = 3'd6
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

endpackage

@@ hw/rtl/sws_req_if.sv @@
// Request channel of the stack: valid/ready handshake plus opcode and key.
// Depends on sws_pkg.
interface sws_req_if;
  import sws_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [KEY_W-1:0] key_value;

  modport source (output valid, output opcode, output key_value, input ready);
  modport sink   (input valid, input opcode, input key_value, output ready);
endinterface

@@ hw/rtl/sws_rsp_if.sv @@
// Response channel of the stack: valid/ready handshake plus result fields.
// Depends on sws_pkg.
interface sws_rsp_if;
  import sws_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] result_value;
  logic [POS_W-1:0]          position;
  logic [FILL_W-1:0]         fill_level;

  modport source (output valid, output status, output result_value,
                  output position, output fill_level, input ready);
  modport sink   (input valid, input status, input result_value,
                  input position, input fill_level, output ready);
endinterface

@@ hw/rtl/sws_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/stack_with_search_delete.sv @@
// LIFO stack of signed Q16.16 keys with push, pop, search, delete, max, min and sum.
// Depends on sws_pkg, sws_req_if, sws_rsp_if and sws_ram.
//
// One request word is taken at a time; every request returns exactly one response word.
// Keys live in a single-port-read, single-port-write RAM, so all work goes through its one
// read port, one entry per cycle. Max, min and sum scan every entry; a search scans from the
// top entry down to the hit or to the bottom. Delete then moves each entry above the hit down
// by one slot to close the gap. The response sits in an output register, so the next
// request is accepted while it waits.
module stack_with_search_delete (
  input  logic clk_i,
  input  logic rst_ni,
  sws_req_if.sink   req_i,
  sws_rsp_if.source rsp_o
);
  import sws_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } state_e;

  state_e                    state_q;
  logic [CNT_W-1:0]          count_q;
  logic [OP_W-1:0]           op_q;
  logic [KEY_W-1:0]          key_q;

  logic [ADDR_W-1:0]         rd_ptr_q;
  logic                      rd_more_q;
  logic                      dv_q;
  logic [ADDR_W-1:0]         di_q;
  logic                      first_q;
  logic signed [VALUE_W-1:0] acc_q;
  logic [ADDR_W-1:0]         sh_wr_q;

  logic [STATUS_W-1:0]       res_status_q;
  logic signed [VALUE_W-1:0] res_value_q;
  logic [POS_W-1:0]          res_pos_q;

  logic                      rsp_valid_q;
  logic [STATUS_W-1:0]       rsp_status_q;
  logic signed [VALUE_W-1:0] rsp_value_q;
  logic [POS_W-1:0]          rsp_pos_q;
  logic [FILL_W-1:0]         rsp_fill_q;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [KEY_W-1:0]          ram_wdata;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [KEY_W-1:0]          ram_rdata;

  logic [CNT_W-1:0]          count_sub1;
  logic                      full;
  logic                      match;
  logic signed [VALUE_W-1:0] rdata_ext;
  logic signed [VALUE_W-1:0] key_ext;
  logic signed [VALUE_W-1:0] acc_new;

  sws_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign count_sub1 = count_q - CNT_W'(1);
  assign full       = (count_q == CNT_W'(DEPTH));
  assign match      = (ram_rdata == key_q);
  assign rdata_ext  = {{(VALUE_W-KEY_W){ram_rdata[KEY_W-1]}}, ram_rdata};
  assign key_ext    = {{(VALUE_W-KEY_W){key_q[KEY_W-1]}}, key_q};

  // Running max, min or sum; the first word scanned seeds it.
  always_comb begin
    if (first_q) begin
      acc_new = rdata_ext;
    end else begin
      case (op_q)
        OP_MAX:  acc_new = (rdata_ext > acc_q) ? rdata_ext : acc_q;
        OP_MIN:  acc_new = (rdata_ext < acc_q) ? rdata_ext : acc_q;
        default: acc_new = acc_q + rdata_ext;
      endcase
    end
  end

  // RAM port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[ADDR_W-1:0];
    ram_wdata = key_q;
    ram_raddr = rd_ptr_q;
    case (state_q)
      ST_START: begin
        ram_raddr = count_sub1[ADDR_W-1:0];
        if (op_q == OP_PUSH && !full) begin
          ram_we = 1'b1;
        end
      end
      ST_SCAN: begin
        // On a delete hit, fetch the word just above it to start closing the gap.
        if (op_q == OP_DELETE && dv_q && match) begin
          ram_raddr = di_q + ADDR_W'(1);
        end
      end
      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = sh_wr_q;
        ram_wdata = ram_rdata;
        ram_raddr = sh_wr_q + ADDR_W'(2);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      dv_q        <= 1'b0;
      rd_more_q   <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      // The finish state drives the response valid itself.
      if (rsp_o.ready && state_q != ST_FINISH) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            op_q    <= req_i.opcode;
            key_q   <= req_i.key_value;
            state_q <= ST_START;
          end
        end
        ST_START: begin
          res_status_q <= STAT_OK;
          res_value_q  <= '0;
          res_pos_q    <= '0;
          dv_q         <= 1'b0;
          di_q         <= count_sub1[ADDR_W-1:0];
          rd_ptr_q     <= ADDR_W'(count_q - CNT_W'(2));
          rd_more_q    <= (count_q > CNT_W'(1));
          first_q      <= 1'b1;
          state_q      <= ST_FINISH;
          case (op_q)
            OP_PUSH: begin
              if (full) begin
                res_status_q <= STAT_FULL;
              end else begin
                count_q     <= count_q + CNT_W'(1);
                res_value_q <= key_ext;
              end
            end
            OP_POP, OP_MAX, OP_MIN, OP_SUM: begin
              if (count_q == '0) begin
                res_status_q <= STAT_EMPTY;
              end else begin
                dv_q    <= 1'b1;
                state_q <= ST_SCAN;
              end
            end
            OP_SEARCH, OP_DELETE: begin
              if (count_q == '0) begin
                res_status_q <= STAT_NOTFOUND;
              end else begin
                dv_q    <= 1'b1;
                state_q <= ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
        ST_SCAN: begin
          // Advance the read pointer toward the bottom.
          dv_q <= rd_more_q;
          di_q <= rd_ptr_q;
          if (rd_more_q) begin
            rd_ptr_q  <= rd_ptr_q - ADDR_W'(1);
            rd_more_q <= (rd_ptr_q != '0);
          end
          if (dv_q) begin
            case (op_q)
              OP_POP: begin
                count_q     <= count_sub1;
                res_value_q <= rdata_ext;
                state_q     <= ST_FINISH;
              end
              OP_SEARCH, OP_DELETE: begin
                if (match) begin
                  res_value_q <= rdata_ext;
                  res_pos_q   <= POS_W'(count_sub1 - {1'b0, di_q});
                  state_q     <= ST_FINISH;
                  if (op_q == OP_DELETE) begin
                    if ({1'b0, di_q} == count_sub1) begin
                      count_q <= count_sub1;
                    end else begin
                      sh_wr_q <= di_q;
                      state_q <= ST_SHIFT;
                    end
                  end
                end else if (di_q == '0) begin
                  res_status_q <= STAT_NOTFOUND;
                  state_q      <= ST_FINISH;
                end
              end
              default: begin
                acc_q   <= acc_new;
                first_q <= 1'b0;
                if (di_q == '0) begin
                  res_value_q <= acc_new;
                  state_q     <= ST_FINISH;
                end
              end
            endcase
          end
        end
        ST_SHIFT: begin
          // Each cycle moves one word down by one slot.
          if ({1'b0, sh_wr_q} + CNT_W'(1) == count_sub1) begin
            count_q <= count_sub1;
            state_q <= ST_FINISH;
          end else begin
            sh_wr_q <= sh_wr_q + ADDR_W'(1);
          end
        end
        ST_FINISH: begin
          // Hold until the response register is free.
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= res_status_q;
            rsp_value_q  <= res_value_q;
            rsp_pos_q    <= res_pos_q;
            rsp_fill_q   <= FILL_W'(count_q);
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready        = (state_q == ST_IDLE);
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.result_value = rsp_value_q;
  assign rsp_o.position     = rsp_pos_q;
  assign rsp_o.fill_level   = rsp_fill_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.opcode == OP_PUSH && !full)
      |-> ##2 (count_q == $past(count_q, 2) + CNT_W'(1)))
    else $error("push did not grow the stack by one");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && dv_q) |-> ({1'b0, di_q} < count_q))
    else $error("scan read beyond the fill level");

endmodule
